/* rtl/core/fis_pkg.sv */
// shared types and helpers for the float insertion sorter
package fis_pkg;

	typedef struct packed {
		logic [31:0] value;
		logic        last;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] sorted_value;
		logic        end_of_set;
		logic        overflow;
	} out_beat_t;

	// map a float bit pattern to an unsigned key in float order, -0 equal to +0
	function automatic logic [31:0] order_key(input logic [31:0] bits);
		logic [31:0] b;
		b = (bits[30:0] == 31'd0) ? 32'd0 : bits;
		return b[31] ? ~b : (b | 32'h8000_0000);
	endfunction

endpackage

/* rtl/core/fis_cell.sv */
// one cell of the insertion chain: holds one element, shifts in sort or drain mode
module fis_cell (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ins,        // insert beat broadcast to all cells
	input  logic [31:0] ins_value,
	input  logic        drain,      // shift one place toward the head
	input  logic        left_valid, // neighbor toward the head
	input  logic        left_gt,    // neighbor's key is greater than the new one
	input  logic [31:0] left_value,
	input  logic        right_valid, // neighbor toward the tail
	input  logic [31:0] right_value,
	output logic        valid,
	output logic        gt,
	output logic [31:0] value
);
	logic        valid_q;
	logic [31:0] value_q;

	assign valid = valid_q;
	assign value = value_q;
	assign gt    = valid_q && (fis_pkg::order_key(value_q) > fis_pkg::order_key(ins_value));

	// occupancy: the first empty cell fills on an insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (drain) begin
			valid_q <= right_valid;
		end else if (ins) begin
			valid_q <= valid_q || left_valid;
		end
	end

	// data: take the neighbor's element when it moves down, or the new one
	always_ff @(posedge clk) begin
		if (drain) begin
			value_q <= right_value;
		end else if (ins) begin
			if (left_gt) begin
				value_q <= left_value;
			end else if (gt || !valid_q) begin
				value_q <= ins_value;
			end
		end
	end
endmodule

/* rtl/core/float_insertion_sorter.sv */
// top level of the float insertion sorter
// Sorts a set of single-precision floats in a chain of DEPTH cells, each
// comparing its element with the new one so that one element is taken each
// cycle. Equal keys keep arrival order; -0 equals +0. On the element marked
// last the set leaves head first, one beat a cycle while out_stall is low,
// with end_of_set on the greatest and overflow if elements beyond DEPTH
// were dropped. Input is stalled while a set drains.
module float_insertion_sorter #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  fis_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output fis_pkg::out_beat_t out_data
);
	logic [DEPTH-1:0] v, g;
	logic [31:0]      d [DEPTH];
	logic             draining_q, drop_q, ins, drain, acc;

	assign in_stall  = draining_q;
	assign acc       = in_valid && !draining_q;
	// a full chain drops the element
	assign ins       = acc && !v[DEPTH-1];
	assign out_valid = draining_q;
	assign drain     = draining_q && !out_stall;
	assign out_data.sorted_value = d[0];
	assign out_data.end_of_set   = (DEPTH > 1) ? !v[1] : 1'b1;
	assign out_data.overflow     = drop_q;

	// chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic        lv, lg, rv;
		logic [31:0] lval, rval;
		if (i == 0) begin : g_head
			assign lv = 1'b1; assign lg = 1'b0; assign lval = in_data.value;
		end else begin : g_mid
			assign lv = v[i-1]; assign lg = g[i-1]; assign lval = d[i-1];
		end
		if (i == DEPTH-1) begin : g_tail
			assign rv = 1'b0; assign rval = in_data.value;
		end else begin : g_body
			assign rv = v[i+1]; assign rval = d[i+1];
		end
		fis_cell u_cell (
			.clk, .arst_n, .ins, .ins_value(in_data.value), .drain,
			.left_valid(lv), .left_gt(lg), .left_value(lval),
			.right_valid(rv), .right_value(rval),
			.valid(v[i]), .gt(g[i]), .value(d[i])
		);
	end

	// set control: drain after last, drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			drop_q     <= 1'b0;
		end else if (acc) begin
			if (v[DEPTH-1]) drop_q <= 1'b1;
			if (in_data.last) draining_q <= 1'b1;
		end else if (drain && out_data.end_of_set) begin
			draining_q <= 1'b0;
			drop_q     <= 1'b0;
		end
	end
endmodule
